// ===== src/fade_envelope_timer_assert.svh =====
// assertion macros shared by the fade envelope timer modules
`ifndef FADE_ENVELOPE_TIMER_ASSERT_SVH
`define FADE_ENVELOPE_TIMER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define FET_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define FET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fet_pkg.sv =====
// types and constants of the fade envelope timer
package fet_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FX_W      = FRAC_BITS + 1;
  localparam int TIME_W    = 16;
  localparam int DELTA_W   = 16;
  localparam int DUR_W     = 24;
  localparam int ELAPSED_W = 25;
  localparam int REQ_W     = 2;
  localparam int DIVD_W    = DELTA_W + FRAC_BITS;
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_CYCLES = DIVD_W / DIV_BITS_PER_CYCLE;
  localparam int CNT_W     = $clog2(DIV_CYCLES);
  localparam int CFG_IDX_W = 1;

  localparam logic [FX_W-1:0]   ONE_FX = FX_W'(1) << FRAC_BITS;
  localparam logic [TIME_W-1:0] FADE_TIME_RESET = TIME_W'(300);

  localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SHOW = 2'd1;
  localparam logic [REQ_W-1:0] REQ_HIDE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT = 1'd1;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [DELTA_W-1:0] delta_time;
    logic [DUR_W-1:0]   show_duration;
  } in_item_t;

  typedef struct packed {
    logic [FX_W-1:0] opacity;
    logic            hide_now;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic prog;
    logic sq;
    logic cube;
    logic steady;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic fading;
    logic out_free;
  } dp_status_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DIV    = 7'b0000010,
    S_PROG   = 7'b0000100,
    S_SQ     = 7'b0001000,
    S_CUBE   = 7'b0010000,
    S_STEADY = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

endpackage

// ===== src/fet_ctrl.sv =====
// sequencing state machine of the fade envelope timer
`include "fade_envelope_timer_assert.svh"

module fet_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [fet_pkg::REQ_W-1:0]      req_type,
  output logic                           in_ready,
  input  fet_pkg::dp_status_t            status,
  output fet_pkg::dp_cmd_t               cmd
);
  import fet_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (req_type == REQ_TICK) begin
            state_next = status.fading ? S_DIV : S_STEADY;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          state_next = S_PROG;
        end
      end
      S_PROG: begin
        cmd.prog   = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq     = 1'b1;
        state_next = S_CUBE;
      end
      S_CUBE: begin
        cmd.cube   = 1'b1;
        state_next = S_OUT;
      end
      S_STEADY: begin
        cmd.steady = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `FET_ASSERT_NEXT(a_fade_tick_divides, (state == S_IDLE) && in_valid && (req_type == REQ_TICK) && status.fading, state == S_DIV, "fading tick did not start the divider")
  `FET_ASSERT_NEXT(a_div_ends, (state == S_DIV) && (cnt == CNT_LAST), state == S_PROG, "divider did not end after its last step")
  `FET_ASSERT_NEXT(a_out_holds, (state == S_OUT) && !status.out_free, state == S_OUT, "result dropped while output register busy")

endmodule

// ===== src/fet_datapath.sv =====
// envelope state, shared divider and multiplier, output register
`include "fade_envelope_timer_assert.svh"

module fet_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  fet_pkg::in_item_t               in_item,
  input  logic                            cfg_we,
  input  logic [fet_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fet_pkg::TIME_W-1:0]      cfg_data,
  input  fet_pkg::dp_cmd_t                cmd,
  output fet_pkg::dp_status_t             status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fet_pkg::out_item_t              out_item
);
  import fet_pkg::*;

  logic [TIME_W-1:0]    fade_in_time, fade_out_time;
  logic                 visible, fading_in, fading_out;
  logic [FX_W-1:0]      progress;
  logic [ELAPSED_W-1:0] elapsed_ms;
  logic [DUR_W-1:0]     auto_hide_ms;

  logic [DELTA_W-1:0]   delta;
  logic                 tick_in;
  logic [TIME_W-1:0]    div_d;
  logic [TIME_W-1:0]    rem, rem_next;
  logic [DIVD_W-1:0]    quo, quo_next;
  logic [TIME_W:0]      rem_sh;
  logic [TIME_W-1:0]    sel_time;

  logic [DIVD_W:0]      p_sum;
  logic [FX_W-1:0]      p_new;
  logic [FX_W-1:0]      q, sq, res_opacity;
  logic                 res_hide;
  logic [2*FX_W-1:0]    prod;
  logic [FX_W-1:0]      mul_a;
  logic [ELAPSED_W:0]   e_sum;
  logic [ELAPSED_W-1:0] e_sat;

  // divisor for the coming fade tick, zero taken as one
  always_comb begin
    sel_time = fading_in ? fade_in_time : fade_out_time;
    if (sel_time == '0) begin
      sel_time = TIME_W'(1);
    end
  end

  // restoring division, a few quotient bits a cycle
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    rem_sh   = '0;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      rem_sh   = {rem_next, quo_next[DIVD_W-1]};
      quo_next = {quo_next[DIVD_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, div_d}) begin
        rem_sh      = rem_sh - {1'b0, div_d};
        quo_next[0] = 1'b1;
      end
      rem_next = rem_sh[TIME_W-1:0];
    end
  end

  always_comb begin
    p_sum = (DIVD_W+1)'(progress) + (DIVD_W+1)'(quo);
    p_new = (p_sum >= (DIVD_W+1)'(ONE_FX)) ? ONE_FX : p_sum[FX_W-1:0];
  end

  // one shared multiplier: q*q, then square*q
  assign mul_a = cmd.cube ? sq : q;
  assign prod  = mul_a * q;

  always_comb begin
    e_sum = (ELAPSED_W+1)'(elapsed_ms) + (ELAPSED_W+1)'(delta);
    e_sat = e_sum[ELAPSED_W] ? '1 : e_sum[ELAPSED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_in_time  <= FADE_TIME_RESET;
      fade_out_time <= FADE_TIME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FADE_IN:  fade_in_time  <= cfg_data;
        CFG_FADE_OUT: fade_out_time <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visible      <= 1'b0;
      fading_in    <= 1'b0;
      fading_out   <= 1'b0;
      progress     <= '0;
      elapsed_ms   <= '0;
      auto_hide_ms <= '0;
    end else begin
      if (cmd.accept) begin
        if (in_item.req_type == REQ_SHOW) begin
          auto_hide_ms <= in_item.show_duration;
          elapsed_ms   <= '0;
          visible      <= 1'b1;
          fading_in    <= 1'b1;
          fading_out   <= 1'b0;
          progress     <= '0;
        end else if (in_item.req_type == REQ_HIDE && (visible || fading_in)) begin
          fading_out <= 1'b1;
          fading_in  <= 1'b0;
          progress   <= '0;
        end
      end
      if (cmd.prog) begin
        progress <= p_new;
        if (p_new == ONE_FX) begin
          if (tick_in) begin
            fading_in <= 1'b0;
          end else begin
            fading_out <= 1'b0;
            visible    <= 1'b0;
          end
        end
      end
      if (cmd.steady && visible && auto_hide_ms != '0) begin
        elapsed_ms <= e_sat;
        if (e_sat >= ELAPSED_W'(auto_hide_ms)) begin
          fading_out <= 1'b1;
          fading_in  <= 1'b0;
          progress   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      delta   <= in_item.delta_time;
      tick_in <= fading_in;
      div_d   <= sel_time;
      rem     <= '0;
      quo     <= {in_item.delta_time, FRAC_BITS'(0)};
    end
    if (cmd.div_step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
    if (cmd.prog) begin
      q        <= ONE_FX - p_new;
      res_hide <= !tick_in && (p_new == ONE_FX);
    end
    if (cmd.sq) begin
      sq <= prod[FRAC_BITS +: FX_W];
      if (!tick_in) begin
        res_opacity <= res_hide ? '0 : prod[FRAC_BITS +: FX_W];
      end
    end
    if (cmd.cube && tick_in) begin
      res_opacity <= ONE_FX - prod[FRAC_BITS +: FX_W];
    end
    if (cmd.steady) begin
      res_opacity <= ONE_FX;
      res_hide    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.opacity  <= res_opacity;
      out_item.hide_now <= res_hide;
    end
  end

  assign status.fading   = fading_in || fading_out;
  assign status.out_free = !out_valid || out_ready;

  `FET_ASSERT_NOW(a_one_fade_dir, fading_in, !fading_out, "fading in and out at once")
  `FET_ASSERT_NOW(a_fade_in_visible, fading_in, visible, "fading in while not visible")
  `FET_ASSERT_NOW(a_progress_range, 1'b1, progress <= ONE_FX, "fade progress beyond one")

endmodule

// ===== src/fade_envelope_timer.sv =====
// top level of the fade envelope timer
// Show, hide and ignored commands give no result. A tick while idle or steady
// is accepted, does the steady update and loads the output. A tick during a
// fade: accept, the shared restoring divider at two quotient bits per cycle,
// a progress update, two passes through the one 17x17 multiplier, and the
// output load. One item is in work at a time; a finished result waits in the
// output register while the next item is accepted, and a later tick holds in
// its last cycle until that register is free. Fractions are Q1.16 with 65536
// as fully opaque; a zero fade time acts as one millisecond.
module fade_envelope_timer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fet_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fet_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic [fet_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fet_pkg::TIME_W-1:0]      cfg_data
);
  import fet_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  fet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (in_item.req_type),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fet_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
